// ===== rtl/core/fnvh_pkg.sv =====
// shared types and constants for the fnv-1a hash table
`timescale 1ns / 1ps
package fnvh_pkg;
  localparam int TableDepth  = 256;
  localparam int MaxKeyBytes = 8;
  localparam int IdxW = $clog2(TableDepth);
  localparam int CntW = IdxW + 1;
  localparam int LenW = 4;
  localparam int KeyW = 64;
  localparam int ValW = 32;
  localparam logic [63:0] FnvBasis   = 64'hcbf29ce484222325;
  localparam logic [63:0] FnvPrimeLo = 64'h00000000000001b3;

  localparam logic [1:0] CMD_SET = 2'd0;
  localparam logic [1:0] CMD_GET = 2'd1;
  localparam logic [1:0] CMD_DEL = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [KeyW-1:0] key;
    logic [LenW-1:0] len;
    logic [ValW-1:0] value;
  } slot_t;

  // controller to datapath
  typedef struct packed {
    logic load_in;
    logic hash_step;
    logic probe_init;
    logic rd_idx;
    logic probe_next;
    logic decide;
    logic del_adv;
    logic rd_j;
    logic del_load;
    logic del_move;
    logic del_finish;
    logic out_load;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic hash_done;
    logic idx_used;
    logic key_match;
    logic probe_last;
    logic del_take;
    logic del_stop;
    logic move;
    logic out_free;
  } dp_stat_t;
endpackage

// ===== rtl/core/fnvh_ram.sv =====
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
module fnvh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ===== rtl/core/fnvh_datapath.sv =====
// hash unit, probe registers, slot memory, occupancy bits and result register
`timescale 1ns / 1ps
module fnvh_datapath (
  input  logic                clk,
  input  logic                rst,
  input  fnvh_pkg::dp_cmd_t   cmd,
  output fnvh_pkg::dp_stat_t  stat,
  input  logic [103:0]        s_tdata,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [39:0]         m_tdata
);
  logic [1:0]                  op;
  logic [fnvh_pkg::KeyW-1:0]   key;
  logic [fnvh_pkg::LenW-1:0]   len;
  logic [fnvh_pkg::ValW-1:0]   vin;
  logic [63:0]                 h;
  logic [63:0]                 hk;
  logic [fnvh_pkg::LenW-1:0]   hl;
  logic [fnvh_pkg::LenW-1:0]   rcnt;
  logic [fnvh_pkg::IdxW-1:0]   idx;
  logic [fnvh_pkg::IdxW-1:0]   hole;
  logic [fnvh_pkg::IdxW-1:0]   j;
  logic [fnvh_pkg::CntW-1:0]   n;
  logic [fnvh_pkg::CntW-1:0]   count;
  logic                        found;
  logic [fnvh_pkg::TableDepth-1:0] used;
  logic [1:0]                  status;
  logic [fnvh_pkg::ValW-1:0]   vout;
  fnvh_pkg::slot_t             mv;
  fnvh_pkg::slot_t             rdata;

  logic [fnvh_pkg::LenW-1:0]   in_len;
  logic [63:0]                 in_key;
  logic [63:0]                 hx;
  logic [63:0]                 h_next;
  logic [fnvh_pkg::IdxW-1:0]   hs;
  logic                        ram_we;
  logic [fnvh_pkg::IdxW-1:0]   waddr;
  fnvh_pkg::slot_t             wdata;
  logic                        can_insert;

  // saturate length and trim key bytes
  always_comb begin
    in_len = (s_tdata[69:66] > fnvh_pkg::LenW'(fnvh_pkg::MaxKeyBytes)) ?
             fnvh_pkg::LenW'(fnvh_pkg::MaxKeyBytes) : s_tdata[69:66];
    for (int i = 0; i < 8; i++) begin
      in_key[8*i +: 8] = (fnvh_pkg::LenW'(i) < in_len) ? s_tdata[2 + 8*i +: 8] : 8'h00;
    end
  end

  // one fnv-1a round: prime is 2^40 + 0x1b3
  always_comb begin
    hx = h ^ {56'd0, hk[8*rcnt[2:0] +: 8]};
    h_next = (hx << 40) + 64'(hx * fnvh_pkg::FnvPrimeLo);
  end
  assign hs = h[fnvh_pkg::IdxW-1:0];

  // backward-shift move test for the slot at j against the hole
  assign stat.move = (j > hole) ? ((hs <= hole) || (hs > j)) : ((hs <= hole) && (hs > j));

  assign can_insert = (count < fnvh_pkg::CntW'(fnvh_pkg::TableDepth / 2)) && !used[idx];

  assign stat.hash_done  = (rcnt == hl);
  assign stat.idx_used   = used[idx];
  assign stat.key_match  = (rdata.len == len) && (rdata.key == key);
  assign stat.probe_last = (n == fnvh_pkg::CntW'(fnvh_pkg::TableDepth - 1));
  assign stat.del_take   = (op == fnvh_pkg::CMD_DEL) && found;
  assign stat.del_stop   = !used[j] || (j == hole);
  assign stat.out_free   = !m_tvalid || m_tready;

  // slot memory write select
  always_comb begin
    ram_we = 1'b0;
    waddr  = idx;
    wdata  = '{key: key, len: len, value: vin};
    if (cmd.decide && op == fnvh_pkg::CMD_SET && (found || can_insert)) begin
      ram_we = 1'b1;
    end
    if (cmd.del_move && stat.move) begin
      ram_we = 1'b1;
      waddr  = hole;
      wdata  = mv;
    end
  end

  fnvh_ram #(
    .WIDTH($bits(fnvh_pkg::slot_t)),
    .DEPTH(fnvh_pkg::TableDepth)
  ) u_slots (
    .clk  (clk),
    .we   (ram_we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (cmd.rd_idx || cmd.rd_j),
    .raddr(cmd.rd_j ? j : idx),
    .rdata(rdata)
  );

  // request, hash and probe registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op   <= s_tdata[1:0];
      key  <= in_key;
      len  <= in_len;
      vin  <= s_tdata[101:70];
      h    <= fnvh_pkg::FnvBasis;
      hk   <= in_key;
      hl   <= in_len;
      rcnt <= '0;
    end
    if (cmd.del_load) begin
      mv   <= rdata;
      h    <= fnvh_pkg::FnvBasis;
      hk   <= rdata.key;
      hl   <= rdata.len;
      rcnt <= '0;
    end
    if (cmd.hash_step) begin
      h    <= h_next;
      rcnt <= rcnt + 1'b1;
    end
    if (cmd.probe_init) begin
      idx   <= hs;
      n     <= '0;
      found <= 1'b0;
    end
    if (cmd.probe_next) begin
      if (stat.key_match) begin
        found <= 1'b1;
      end else begin
        idx <= idx + 1'b1;
        n   <= n + 1'b1;
      end
    end
    if (cmd.decide) begin
      hole <= idx;
      j    <= idx;
      vout <= '0;
      unique case (op)
        fnvh_pkg::CMD_SET: status <= (found || can_insert) ? fnvh_pkg::ST_OK : fnvh_pkg::ST_FULL;
        fnvh_pkg::CMD_GET: begin
          status <= found ? fnvh_pkg::ST_OK : fnvh_pkg::ST_MISS;
          if (found) begin
            vout <= rdata.value;
          end
        end
        fnvh_pkg::CMD_DEL: status <= found ? fnvh_pkg::ST_OK : fnvh_pkg::ST_MISS;
        default:           status <= fnvh_pkg::ST_MISS;
      endcase
    end
    if (cmd.del_adv) begin
      j <= j + 1'b1;
    end
    if (cmd.del_move && stat.move) begin
      hole <= j;
    end
  end

  // occupancy, entry count and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      used     <= '0;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.decide && op == fnvh_pkg::CMD_SET && !found && can_insert) begin
        used[idx] <= 1'b1;
        count     <= count + 1'b1;
      end
      if (cmd.del_finish) begin
        used[hole] <= 1'b0;
        if (count != '0) begin
          count <= count - 1'b1;
        end
      end
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= {6'd0, vout, status};
    end
  end
endmodule

// ===== rtl/core/fnvh_ctrl.sv =====
// sequencer for hashing, probing, update and backward-shift delete
`timescale 1ns / 1ps
module fnvh_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  fnvh_pkg::dp_stat_t  stat,
  output fnvh_pkg::dp_cmd_t   cmd
);
  typedef enum logic [3:0] {
    S_IDLE, S_HASH, S_PROBE, S_CMP, S_DECIDE, S_DADV, S_DRD, S_DLOAD,
    S_DHASH, S_DCHK, S_DONE
  } state_t;

  state_t state;
  state_t state_next;

  assign s_tready = (state == S_IDLE) && !rst;

  // next state and datapath commands
  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid && s_tready) begin
          cmd.load_in = 1'b1;
          state_next  = S_HASH;
        end
      end
      S_HASH: begin
        if (stat.hash_done) begin
          cmd.probe_init = 1'b1;
          state_next     = S_PROBE;
        end else begin
          cmd.hash_step = 1'b1;
        end
      end
      S_PROBE: begin
        if (stat.idx_used) begin
          cmd.rd_idx = 1'b1;
          state_next = S_CMP;
        end else begin
          state_next = S_DECIDE;
        end
      end
      S_CMP: begin
        cmd.probe_next = 1'b1;
        state_next = (stat.key_match || stat.probe_last) ? S_DECIDE : S_PROBE;
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_next = stat.del_take ? S_DADV : S_DONE;
      end
      S_DADV: begin
        cmd.del_adv = 1'b1;
        state_next  = S_DRD;
      end
      S_DRD: begin
        if (stat.del_stop) begin
          cmd.del_finish = 1'b1;
          state_next     = S_DONE;
        end else begin
          cmd.rd_j   = 1'b1;
          state_next = S_DLOAD;
        end
      end
      S_DLOAD: begin
        cmd.del_load = 1'b1;
        state_next   = S_DHASH;
      end
      S_DHASH: begin
        if (stat.hash_done) begin
          state_next = S_DCHK;
        end else begin
          cmd.hash_step = 1'b1;
        end
      end
      S_DCHK: begin
        cmd.del_move = 1'b1;
        state_next   = S_DADV;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end
endmodule

// ===== rtl/core/fnv1a_linear_probe_hash_table_unit.sv =====
// key/value table with fnv-1a hashing, linear probing and backward-shift delete
// each request is accepted, hashed one key byte per round and probed along occupied slots
// (a read and a key compare each, a miss ending at the first free slot), then decided and
// handed off; a delete then walks the slots behind the hole, rehashing each stored key
// the unit takes one request at a time, a limit set by the byte-serial hash round and the
// single slot memory read port
`timescale 1ns / 1ps
module fnv1a_linear_probe_hash_table_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [103:0] s_tdata,  // cmd[1:0], key_bytes[65:2], key_len[69:66], value_in[101:70]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [39:0]  m_tdata   // status[1:0], value_out[33:2]
);
  // reset: synchronous, clears all occupancy bits and the entry count at once
  fnvh_pkg::dp_cmd_t  cmd;
  fnvh_pkg::dp_stat_t stat;

  // sequencer
  fnvh_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .stat    (stat),
    .cmd     (cmd)
  );

  // table datapath
  fnvh_datapath u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .stat    (stat),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );
endmodule

// ===== tb/tb_top.sv =====
// self-checking testbench for the fnv-1a linear-probe hash table
`timescale 1ns / 1ps
module tb_top;
  localparam int NumRandom = 1690;
  localparam int WatchLimit = 200000;
  localparam logic [1:0] CmdUnused = 2'd3;

  typedef logic bool_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [103:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [39:0]  m_tdata;

  fnv1a_linear_probe_hash_table_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #1 clk = ~clk;

  typedef struct packed {
    logic [1:0]                status;
    logic [fnvh_pkg::ValW-1:0] value;
  } reply_t;

  // shadow table
  logic [fnvh_pkg::KeyW-1:0] tbl_key [fnvh_pkg::TableDepth];
  logic [fnvh_pkg::LenW-1:0] tbl_len [fnvh_pkg::TableDepth];
  logic [fnvh_pkg::ValW-1:0] tbl_val [fnvh_pkg::TableDepth];
  logic                      tbl_used [fnvh_pkg::TableDepth];
  int                        tbl_count;

  reply_t reply_q[$];
  int     err_cnt = 0;
  int     idle_cycles = 0;
  bool_t  stim_done;

  // keys known to be in play, so gets and deletes hit often
  logic [fnvh_pkg::KeyW-1:0] pool_key [64];
  logic [fnvh_pkg::LenW-1:0] pool_len [64];

  function automatic logic [fnvh_pkg::IdxW-1:0] fnv_slot(logic [fnvh_pkg::KeyW-1:0] k,
                                                         int len);
    logic [63:0] h;
    h = 64'hcbf29ce484222325;
    for (int i = 0; i < len; i++) begin
      h = h ^ {56'd0, k[8*i +: 8]};
      h = h * 64'h100000001b3;
    end
    return h[fnvh_pkg::IdxW-1:0];
  endfunction

  function automatic reply_t table_apply(logic [1:0] cmd, logic [fnvh_pkg::KeyW-1:0] kin,
                                         logic [fnvh_pkg::LenW-1:0] lin,
                                         logic [fnvh_pkg::ValW-1:0] v);
    reply_t r;
    int len, idx, at, hole, j, h;
    logic [fnvh_pkg::KeyW-1:0] k;
    bit found, mv;
    r.status = fnvh_pkg::ST_MISS;
    r.value = '0;
    len = (lin > fnvh_pkg::MaxKeyBytes) ? fnvh_pkg::MaxKeyBytes : int'(lin);
    k = (len >= 8) ? kin : (kin & ((64'd1 << (8 * len)) - 64'd1));
    if (cmd == CmdUnused) return r;
    // probe walk
    idx = int'(fnv_slot(k, len));
    at = idx;
    found = 0;
    for (int n = 0; n < fnvh_pkg::TableDepth; n++) begin
      if (!tbl_used[idx]) begin
        at = idx;
        break;
      end
      if (tbl_len[idx] == len && tbl_key[idx] == k) begin
        at = idx;
        found = 1;
        break;
      end
      idx = (idx + 1) % fnvh_pkg::TableDepth;
    end
    case (cmd)
      fnvh_pkg::CMD_SET: begin
        if (found) begin
          tbl_val[at] = v;
          r.status = fnvh_pkg::ST_OK;
        end else if (tbl_count * 2 >= fnvh_pkg::TableDepth || tbl_used[at]) begin
          r.status = fnvh_pkg::ST_FULL;
        end else begin
          tbl_key[at] = k;
          tbl_len[at] = fnvh_pkg::LenW'(len);
          tbl_val[at] = v;
          tbl_used[at] = 1'b1;
          tbl_count++;
          r.status = fnvh_pkg::ST_OK;
        end
      end
      fnvh_pkg::CMD_GET: begin
        if (found) begin
          r.value = tbl_val[at];
          r.status = fnvh_pkg::ST_OK;
        end
      end
      default: begin
        if (found) begin
          // backward-shift delete
          hole = at;
          j = at;
          for (int n = 0; n < fnvh_pkg::TableDepth; n++) begin
            j = (j + 1) % fnvh_pkg::TableDepth;
            if (!tbl_used[j] || j == hole) break;
            h = int'(fnv_slot(tbl_key[j], int'(tbl_len[j])));
            if (j > hole) mv = (h <= hole) || (h > j);
            else mv = (h <= hole) && (h > j);
            if (mv) begin
              tbl_key[hole] = tbl_key[j];
              tbl_len[hole] = tbl_len[j];
              tbl_val[hole] = tbl_val[j];
              hole = j;
            end
          end
          tbl_used[hole] = 1'b0;
          if (tbl_count > 0) tbl_count--;
          r.status = fnvh_pkg::ST_OK;
        end
      end
    endcase
    return r;
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // send one request, predict and optionally cross-check a typed-in answer
  task automatic send_req(logic [1:0] cmd, logic [fnvh_pkg::KeyW-1:0] k,
                          logic [fnvh_pkg::LenW-1:0] len, logic [fnvh_pkg::ValW-1:0] v,
                          bit has_exp, reply_t exp_r);
    reply_t r;
    int g;
    g = gap_len();
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    s_tdata <= {2'b00, v, len, k, cmd};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    r = table_apply(cmd, k, len, v);
    if (has_exp && r != exp_r) begin
      err_cnt++;
      if (err_cnt <= 10)
        $display("table row mismatch: cmd %0d expected %h predicted %h", cmd, exp_r, r);
    end
    reply_q.push_back(r);
    @(negedge clk);
  endtask

  // result checking
  always @(posedge clk) begin
    reply_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got.status = m_tdata[1:0];
      got.value = m_tdata[33:2];
      if (reply_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("unexpected result %h", got);
      end else begin
        want = reply_q.pop_front();
        if (got.status !== want.status || got.value !== want.value) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("mismatch: status exp %0d got %0d, value exp %h got %h",
                     want.status, got.status, want.value, got.value);
        end
      end
    end
  end

  // receiver stalls
  initial begin
    @(negedge clk);
    forever begin
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      if ($urandom_range(0, 2) == 0) begin
        m_tready <= 1'b0;
        repeat (gap_len() + 1) @(negedge clk);
      end
    end
  end

  // watchdog on transfers
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("** fnv1a_linear_probe_hash_table_unit: FAILED **");
      $finish;
    end
  end

  typedef struct {
    logic [1:0]                cmd;
    logic [fnvh_pkg::KeyW-1:0] key;
    logic [fnvh_pkg::LenW-1:0] len;
    logic [fnvh_pkg::ValW-1:0] val;
    bit                        has_exp;
    reply_t                    exp_r;
  } row_t;

  initial begin
    row_t rows[$];
    logic [1:0] cmd;
    logic [fnvh_pkg::KeyW-1:0] k;
    logic [fnvh_pkg::LenW-1:0] len;
    int p, sel;
    for (int i = 0; i < fnvh_pkg::TableDepth; i++) begin
      tbl_used[i] = 1'b0;
      tbl_key[i] = '0;
      tbl_len[i] = '0;
      tbl_val[i] = '0;
    end
    tbl_count = 0;
    for (int i = 0; i < 64; i++) begin
      pool_key[i] = {$urandom, $urandom};
      pool_len[i] = fnvh_pkg::LenW'($urandom_range(0, 8));
    end
    // directed rows
    rows = '{
      '{fnvh_pkg::CMD_GET, 64'h0, 4'd0, 32'h0, 1, '{fnvh_pkg::ST_MISS, 32'h0}},
      '{fnvh_pkg::CMD_DEL, 64'hffff_ffff_ffff_ffff, 4'd8, 32'h0, 1,
        '{fnvh_pkg::ST_MISS, 32'h0}},
      '{fnvh_pkg::CMD_SET, 64'h0, 4'd0, 32'hffff_ffff, 1, '{fnvh_pkg::ST_OK, 32'h0}},
      '{fnvh_pkg::CMD_GET, 64'h1234, 4'd0, 32'h0, 1, '{fnvh_pkg::ST_OK, 32'hffff_ffff}},
      '{fnvh_pkg::CMD_SET, 64'hffff_ffff_ffff_ffff, 4'd15, 32'h0000_0001, 1,
        '{fnvh_pkg::ST_OK, 32'h0}},
      '{fnvh_pkg::CMD_GET, 64'hffff_ffff_ffff_ffff, 4'd8, 32'h0, 1,
        '{fnvh_pkg::ST_OK, 32'h1}},
      '{fnvh_pkg::CMD_SET, 64'hffff_ffff_ffff_ffff, 4'd9, 32'h5a5a_a5a5, 1,
        '{fnvh_pkg::ST_OK, 32'h0}},
      '{fnvh_pkg::CMD_GET, 64'h00ff_ffff_ffff_ffff, 4'd8, 32'h0, 1,
        '{fnvh_pkg::ST_MISS, 32'h0}},
      '{fnvh_pkg::CMD_SET, 64'haa55, 4'd1, 32'h0000_0002, 1, '{fnvh_pkg::ST_OK, 32'h0}},
      '{fnvh_pkg::CMD_GET, 64'h0055, 4'd1, 32'h0, 1, '{fnvh_pkg::ST_OK, 32'h2}},
      '{fnvh_pkg::CMD_GET, 64'h0055, 4'd2, 32'h0, 1, '{fnvh_pkg::ST_MISS, 32'h0}},
      '{CmdUnused, 64'h55, 4'd1, 32'h7, 1, '{fnvh_pkg::ST_MISS, 32'h0}},
      '{fnvh_pkg::CMD_GET, 64'h55, 4'd1, 32'h0, 1, '{fnvh_pkg::ST_OK, 32'h2}},
      '{fnvh_pkg::CMD_DEL, 64'h55, 4'd1, 32'hdead_beef, 1, '{fnvh_pkg::ST_OK, 32'h0}},
      '{fnvh_pkg::CMD_GET, 64'h55, 4'd1, 32'h0, 1, '{fnvh_pkg::ST_MISS, 32'h0}},
      '{fnvh_pkg::CMD_DEL, 64'h0, 4'd0, 32'h0, 1, '{fnvh_pkg::ST_OK, 32'h0}},
      '{fnvh_pkg::CMD_SET, 64'h0102_0304_0506_0708, 4'd4, 32'h8000_0000, 0,
        '{fnvh_pkg::ST_OK, 32'h0}},
      '{fnvh_pkg::CMD_GET, 64'h0506_0708, 4'd4, 32'h0, 0, '{fnvh_pkg::ST_OK, 32'h0}}
    };
    stim_done = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (rows[i])
      send_req(rows[i].cmd, rows[i].key, rows[i].len, rows[i].val,
               rows[i].has_exp, rows[i].exp_r);
    // fill past the load limit so full status and long probe chains show up
    for (int i = 0; i < 140; i++)
      send_req(fnvh_pkg::CMD_SET, {$urandom, $urandom},
               fnvh_pkg::LenW'($urandom_range(0, 15)), $urandom, 0, '0);
    // random mix, mostly on a pool of keys so hits and shifted deletes occur
    for (int i = 0; i < NumRandom; i++) begin
      p = $urandom_range(0, 99);
      cmd = (p < 40) ? fnvh_pkg::CMD_SET : (p < 70) ? fnvh_pkg::CMD_GET :
            (p < 97) ? fnvh_pkg::CMD_DEL : CmdUnused;
      if ($urandom_range(0, 9) < 8) begin
        sel = (i % 600 < 300) ? $urandom_range(0, 63) : $urandom_range(0, 15);
        k = pool_key[sel];
        len = pool_len[sel];
        if ($urandom_range(0, 3) == 0) k[63:32] = $urandom;
      end else begin
        k = {$urandom, $urandom};
        len = fnvh_pkg::LenW'($urandom_range(0, 15));
      end
      send_req(cmd, k, len, $urandom, 0, '0);
    end
    s_tvalid <= 1'b0;
    stim_done = 1'b1;
  end

  // end of run
  initial begin
    wait (stim_done === 1'b1);
    while (reply_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (err_cnt == 0 && reply_q.size() == 0)
      $display("** fnv1a_linear_probe_hash_table_unit: PASSED **");
    else
      $display("** fnv1a_linear_probe_hash_table_unit: FAILED **");
    $finish;
  end
endmodule
